// File: hdl/dsi256_pkg.sv
// ---------------------------------------------------------------------------
// dsi256_pkg
// Shared constants and types for the decimal string to 256-bit integer block.
// ---------------------------------------------------------------------------
package dsi256_pkg;

  localparam int OUT_BYTES = 32;
  localparam int WORD_W    = 64;
  localparam int NWORDS    = OUT_BYTES / 8;
  localparam int ACC_W     = NWORDS * WORD_W;
  localparam int CNT_W     = (NWORDS > 1) ? $clog2(NWORDS) : 1;

  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [ACC_W-1:0] value;
    logic             neg;
    logic             ok;
  } dsi_result_t;

endpackage

// File: hdl/dsi256_accum.sv
// ---------------------------------------------------------------------------
// dsi256_accum
// Per-string parse state: sign, sticky error and the times-ten accumulator.
// ---------------------------------------------------------------------------
module dsi256_accum (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     consume,
  input  logic [7:0]               char_code,
  input  logic                     last_char,
  output dsi256_pkg::dsi_result_t  result
);

  logic [dsi256_pkg::ACC_W-1:0] acc;
  logic                         is_negative;
  logic                         bad_char_seen;
  logic                         at_first_char;

  logic [dsi256_pkg::ACC_W-1:0] acc_next;
  logic                         is_negative_next;
  logic                         bad_char_seen_next;
  logic                         is_sign;
  logic                         is_digit;
  logic [3:0]                   digit;

  always_comb begin
    is_sign  = at_first_char &&
               (char_code == dsi256_pkg::CH_MINUS || char_code == dsi256_pkg::CH_PLUS);
    is_digit = (char_code >= dsi256_pkg::CH_ZERO) && (char_code <= dsi256_pkg::CH_NINE);
    digit    = 4'(char_code - dsi256_pkg::CH_ZERO);

    is_negative_next   = is_sign ? (char_code == dsi256_pkg::CH_MINUS) : is_negative;
    bad_char_seen_next = bad_char_seen | (!is_sign && !is_digit);

    if (!is_sign && is_digit && !bad_char_seen) begin
      acc_next = {acc[dsi256_pkg::ACC_W-4:0], 3'b000}
               + {acc[dsi256_pkg::ACC_W-2:0], 1'b0}
               + dsi256_pkg::ACC_W'(digit);
    end else begin
      acc_next = acc;
    end

    result.value = acc_next;
    result.neg   = is_negative_next;
    result.ok    = !bad_char_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc           <= '0;
      is_negative   <= 1'b0;
      bad_char_seen <= 1'b0;
      at_first_char <= 1'b1;
    end else if (consume) begin
      if (last_char) begin
        acc           <= '0;
        is_negative   <= 1'b0;
        bad_char_seen <= 1'b0;
        at_first_char <= 1'b1;
      end else begin
        acc           <= acc_next;
        is_negative   <= is_negative_next;
        bad_char_seen <= bad_char_seen_next;
        at_first_char <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/dsi256_serial.sv
// ---------------------------------------------------------------------------
// dsi256_serial
// Result buffer that sends the value as 64-bit words, most significant first,
// negating word by word on the way out.
// ---------------------------------------------------------------------------
module dsi256_serial (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  dsi256_pkg::dsi_result_t  result,
  output logic                     busy,
  output logic                     word_valid,
  input  logic                     word_stall,
  output logic [63:0]              word,
  output logic                     ok,
  output logic                     last_word
);

  localparam logic [dsi256_pkg::CNT_W-1:0] LAST_CNT =
    dsi256_pkg::CNT_W'(dsi256_pkg::NWORDS - 1);

  logic [dsi256_pkg::WORD_W-1:0] words [dsi256_pkg::NWORDS];
  logic                          neg;
  logic                          res_ok;
  logic                          valid;
  logic [dsi256_pkg::CNT_W-1:0]  cnt;
  logic                          leaving;

  logic [dsi256_pkg::NWORDS-1:0] word_zero;
  logic [dsi256_pkg::NWORDS-1:0] below_zero;
  logic [dsi256_pkg::WORD_W-1:0] cur;

  // carry into a word of the negation is set when every lower word is zero
  always_comb begin
    for (int i = 0; i < dsi256_pkg::NWORDS; i++) begin
      word_zero[i] = (words[i] == '0);
    end
    below_zero[dsi256_pkg::NWORDS-1] = 1'b1;
    for (int i = dsi256_pkg::NWORDS - 2; i >= 0; i--) begin
      below_zero[i] = below_zero[i+1] & word_zero[i+1];
    end
    cur = words[cnt];
    if (!res_ok) begin
      word = '0;
    end else if (neg) begin
      word = ~cur + dsi256_pkg::WORD_W'(below_zero[cnt]);
    end else begin
      word = cur;
    end
  end

  // the last word leaving frees the buffer for a load at the same edge
  assign leaving    = valid && !word_stall && (cnt == LAST_CNT);
  assign ok         = res_ok;
  assign last_word  = (cnt == LAST_CNT);
  assign word_valid = valid;
  assign busy       = valid && !leaving;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      cnt   <= '0;
    end else if (load && !busy) begin
      valid <= 1'b1;
      cnt   <= '0;
    end else if (valid && !word_stall) begin
      if (cnt == LAST_CNT) begin
        valid <= 1'b0;
        cnt   <= '0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !busy) begin
      for (int i = 0; i < dsi256_pkg::NWORDS; i++) begin
        words[i] <= result.value[(dsi256_pkg::NWORDS-1-i)*dsi256_pkg::WORD_W +: dsi256_pkg::WORD_W];
      end
      neg    <= result.neg;
      res_ok <= result.ok;
    end
  end

endmodule

// File: hdl/decimal_string_to_int256.sv
// ---------------------------------------------------------------------------
// decimal_string_to_int256
// Takes a signed decimal string one ASCII character per item, with last_char
// on the final one, and returns the 256-bit two's complement value as four
// 64-bit words, most significant first, with ok low and the words zero if any
// character was bad. A '-' or '+' is allowed only as the first character and
// digits wrap modulo 2^256. Characters are taken one per cycle through an
// input register, unless char_stall holds them; each one feeds the 256-bit
// times-ten add. A string ending occupies the output buffer for four word
// transfers, so a following last character waits until the last word of the
// previous result is taken.
// ---------------------------------------------------------------------------
module decimal_string_to_int256 (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_stall,
  input  logic [7:0]  char_code,
  input  logic        last_char,
  output logic        word_valid,
  input  logic        word_stall,
  output logic [63:0] word,
  output logic        ok,
  output logic        last_word
);

  logic       held_valid;
  logic [7:0] held_code;
  logic       held_last;
  logic       consume;
  logic       busy;

  dsi256_pkg::dsi_result_t result;

  assign consume    = held_valid && (!held_last || !busy);
  assign char_stall = held_valid && !consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!char_stall) begin
      held_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && !char_stall) begin
      held_code <= char_code;
      held_last <= last_char;
    end
  end

  dsi256_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .consume   (consume),
    .char_code (held_code),
    .last_char (held_last),
    .result    (result)
  );

  dsi256_serial u_serial (
    .clk        (clk),
    .rst        (rst),
    .load       (consume && held_last),
    .result     (result),
    .busy       (busy),
    .word_valid (word_valid),
    .word_stall (word_stall),
    .word       (word),
    .ok         (ok),
    .last_word  (last_word)
  );

endmodule

// File: hdl/dsi256_checker.sv
// ---------------------------------------------------------------------------
// dsi256_checker
// Port-level checks for decimal_string_to_int256, bound to the top level.
// ---------------------------------------------------------------------------
module dsi256_checker (
  input logic        clk,
  input logic        rst,
  input logic        word_valid,
  input logic        word_stall,
  input logic [63:0] word,
  input logic        ok,
  input logic        last_word
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !word_valid)
    else $error("word_valid after reset");

  a_bad_is_zero: assert property (@(posedge clk) disable iff (rst)
    word_valid && !ok |-> word == 64'd0)
    else $error("nonzero word with ok low");

  a_words_follow: assert property (@(posedge clk) disable iff (rst)
    word_valid && !word_stall && !last_word |=> word_valid && $stable(ok))
    else $error("result words broken up");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    word_valid && word_stall |=> word_valid && $stable(word) && $stable(last_word))
    else $error("stalled item changed");

endmodule

bind decimal_string_to_int256 dsi256_checker u_dsi256_checker (
  .clk        (clk),
  .rst        (rst),
  .word_valid (word_valid),
  .word_stall (word_stall),
  .word       (word),
  .ok         (ok),
  .last_word  (last_word)
);

// File: dv/int256_word_checker.sv
// ---------------------------------------------------------------------------
// int256_word_checker
// Watches the character and word channels of decimal_string_to_int256. It
// keeps its own copy of the 256-bit accumulator, the sign and the error flag.
// For every accepted last character it queues the four expected words. Each
// accepted word is compared field by field with the oldest queued word.
// ---------------------------------------------------------------------------
module int256_word_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  input  logic        char_stall,
  input  logic [7:0]  char_code,
  input  logic        last_char,
  input  logic        word_valid,
  input  logic        word_stall,
  input  logic [63:0] word,
  input  logic        ok,
  input  logic        last_word,
  output int          mismatches,
  output int          words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [dsi256_pkg::WORD_W-1:0] word;
    logic                          ok;
    logic                          last_word;
  } word_item_t;

  word_item_t                   expected_words[$];
  word_item_t                   oldest_word;
  logic [dsi256_pkg::ACC_W-1:0] acc;
  logic                         minus_seen;
  logic                         bad_seen;
  logic                         first_pos;

  initial begin
    mismatches    = 0;
    words_pending = 0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic void clear_string();
    acc        = '0;
    minus_seen = 1'b0;
    bad_seen   = 1'b0;
    first_pos  = 1'b1;
  endfunction

  task automatic predict_char(input logic [7:0] c, input logic is_last);
    word_item_t w;
    if (first_pos && (c == dsi256_pkg::CH_MINUS || c == dsi256_pkg::CH_PLUS)) begin
      minus_seen = (c == dsi256_pkg::CH_MINUS);
    end else if (c >= dsi256_pkg::CH_ZERO && c <= dsi256_pkg::CH_NINE) begin
      if (!bad_seen) acc = acc * 10 + (c - dsi256_pkg::CH_ZERO);
    end else begin
      bad_seen = 1'b1;
    end
    first_pos = 1'b0;
    if (is_last) begin
      if (minus_seen && !bad_seen) acc = ~acc + 1'b1;
      for (int k = 0; k < dsi256_pkg::NWORDS; k++) begin
        w.word      = bad_seen ? '0 :
                      acc[dsi256_pkg::ACC_W-1-k*dsi256_pkg::WORD_W -: dsi256_pkg::WORD_W];
        w.ok        = !bad_seen;
        w.last_word = (k == dsi256_pkg::NWORDS - 1);
        expected_words.push_back(w);
      end
      clear_string();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_string();
      expected_words.delete();
    end else begin
      // words first: a word never comes from the character of the same edge
      if (word_valid && !word_stall) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h ok %b last %b", word, ok,
                                    last_word));
        end else begin
          oldest_word = expected_words.pop_front();
          if (word !== oldest_word.word)
            report_mismatch($sformatf("word %h, want %h", word, oldest_word.word));
          if (ok !== oldest_word.ok)
            report_mismatch($sformatf("ok %b, want %b", ok, oldest_word.ok));
          if (last_word !== oldest_word.last_word)
            report_mismatch($sformatf("last_word %b, want %b", last_word,
                                      oldest_word.last_word));
        end
      end
      if (char_valid && !char_stall) predict_char(char_code, last_char);
    end
    words_pending <= expected_words.size();
  end

endmodule

// File: dv/decimal_string_to_int256_tb.sv
// ---------------------------------------------------------------------------
// decimal_string_to_int256_tb
// Drives decimal strings into decimal_string_to_int256, one character per
// item: a few hand-picked strings first, then random well-formed, broken and
// noise strings under three sender and receiver idling mixes. The checker
// beside the block predicts and compares the words; this module gives the
// verdict.
// ---------------------------------------------------------------------------
module decimal_string_to_int256_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 20;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        char_valid = 1'b0;
  logic        char_stall;
  logic [7:0]  char_code  = 8'h00;
  logic        last_char  = 1'b0;
  logic        word_valid;
  logic        word_stall = 1'b0;
  logic [63:0] word;
  logic        ok;
  logic        last_word;

  int          mismatches;
  int          words_pending;
  int          send_gap_pct   = 30;
  int          word_stall_pct = 76;
  int          chars_sent     = 0;
  int          quiet_cycles   = 0;
  logic [7:0]  text[$];

  decimal_string_to_int256 dut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_code  (char_code),
    .last_char  (last_char),
    .word_valid (word_valid),
    .word_stall (word_stall),
    .word       (word),
    .ok         (ok),
    .last_word  (last_word)
  );

  int256_word_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .char_valid    (char_valid),
    .char_stall    (char_stall),
    .char_code     (char_code),
    .last_char     (last_char),
    .word_valid    (word_valid),
    .word_stall    (word_stall),
    .word          (word),
    .ok            (ok),
    .last_word     (last_word),
    .mismatches    (mismatches),
    .words_pending (words_pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    word_stall <= ($urandom_range(99) < word_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (char_valid && !char_stall) || (word_valid && !word_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input logic is_last);
    while ($urandom_range(99) < send_gap_pct) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    char_code  <= c;
    last_char  <= is_last;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text();
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
  endtask

  task automatic send_ascii(input string s);
    text.delete();
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    send_text();
  endtask

  task automatic send_random_string();
    int kind;
    int ndig;
    int pos;
    text.delete();
    kind = $urandom_range(9);
    if (kind >= 8) begin
      // noise
      repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(255)));
    end else begin
      pos = $urandom_range(2);
      if (pos == 1) text.push_back(dsi256_pkg::CH_MINUS);
      else if (pos == 2) text.push_back(dsi256_pkg::CH_PLUS);
      // a few long strings of 60 to 80 digits; the longest wrap past 2^256
      ndig = ($urandom_range(11) == 0) ? $urandom_range(60, 80) : $urandom_range(1, 8);
      repeat (ndig) text.push_back(dsi256_pkg::CH_ZERO + 8'($urandom_range(9)));
      if (kind >= 6) begin
        pos = $urandom_range(text.size() - 1);
        if (pos > 0 && $urandom_range(1) == 1)
          text[pos] = ($urandom_range(1) == 1) ? dsi256_pkg::CH_MINUS : dsi256_pkg::CH_PLUS;
        else
          text[pos] = 8'($urandom_range(255));
      end
    end
    send_text();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_ascii("0");
    send_ascii("-");
    send_ascii("+");
    send_ascii("-1");
    send_ascii("+9");
    send_ascii("-0");
    send_ascii("1-");
    send_ascii("--");
    send_ascii("x5");
    send_ascii("/");
    send_ascii(":");
    send_char(8'hff, 1'b1);
    send_char(8'h00, 1'b1);

    while (chars_sent < 90) send_random_string();
    send_gap_pct   = 76;
    word_stall_pct = 30;
    while (chars_sent < 160) send_random_string();
    send_gap_pct   = 0;
    word_stall_pct = 0;
    while (chars_sent < 220) send_random_string();

    char_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
